FILE: sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the barometric compensation block
// Transfer structs, datapath widths, register indexes and the scale table.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int RAW_W    = 24;
  localparam int OUT_W    = 32;
  localparam int FRAC     = 24;
  localparam int VAL_W    = 58;
  localparam int MA_W     = 52;
  localparam int MB_W     = 36;
  localparam int K_W      = 23;
  localparam int DIV_W    = RAW_W + FRAC;
  localparam int OS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int Q8_SHIFT = 16;
  localparam int ROUND_Q8 = 1 << (Q8_SHIFT - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COEFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_COEFS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC_COEF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_OS     = 3'd5;

  typedef struct packed {
    logic                    cmd;
    logic signed [RAW_W-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic signed [OUT_W-1:0] compensated;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic rnd;
  } mul_cmd_t;

  typedef struct packed {
    logic            start;
    logic [OS_W-1:0] code;
  } div_cmd_t;

  function automatic logic [K_W-1:0] scale_k(input logic [OS_W-1:0] code);
    logic [K_W-1:0] k;
    unique case (code)
      3'd0: k = 23'd524288;
      3'd1: k = 23'd1572864;
      3'd2: k = 23'd3670016;
      3'd3: k = 23'd7864320;
      3'd4: k = 23'd253952;
      3'd5: k = 23'd516096;
      3'd6: k = 23'd1040384;
      3'd7: k = 23'd2088960;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/bpc_scale_div.sv
// ----------------------------------------------------------------------------
// bpc_scale_div: bit-serial scaling divider
// Divides a raw reading, shifted up by the fraction width, by the selected
// scale factor, one quotient bit per cycle, rounding half away from zero.
// ----------------------------------------------------------------------------
module bpc_scale_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bpc_pkg::div_cmd_t                      cmd,
  input  logic signed [bpc_pkg::RAW_W-1:0]       raw,
  output logic                                   done,
  output logic signed [bpc_pkg::VAL_W-1:0]       quot
);

  localparam int CNT_W = $clog2(bpc_pkg::DIV_W);

  logic                            busy_r;
  logic                            fin_r;
  logic                            done_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            neg_r;
  logic [bpc_pkg::K_W-1:0]         k_r;
  logic [bpc_pkg::K_W-1:0]         rem_r;
  logic [bpc_pkg::DIV_W-1:0]       q_r;
  logic signed [bpc_pkg::VAL_W-1:0] quot_r;

  logic [bpc_pkg::RAW_W-1:0]       raw_mag;
  logic [bpc_pkg::K_W-1:0]         k_sel;
  logic [bpc_pkg::DIV_W-1:0]       dividend;
  logic [bpc_pkg::K_W:0]           trial;
  logic [bpc_pkg::K_W:0]           diff;
  logic                            ge;
  logic [bpc_pkg::K_W-1:0]         rem_nxt;
  logic [bpc_pkg::DIV_W-1:0]       q_nxt;
  logic signed [bpc_pkg::VAL_W-1:0] q_ext;

  always_comb begin
    raw_mag  = raw[bpc_pkg::RAW_W-1] ? bpc_pkg::RAW_W'(-raw) : bpc_pkg::RAW_W'(raw);
    k_sel    = bpc_pkg::scale_k(cmd.code);
    dividend = {raw_mag, {bpc_pkg::FRAC{1'b0}}} | bpc_pkg::DIV_W'(k_sel >> 1);
    trial    = {rem_r, q_r[bpc_pkg::DIV_W-1]};
    diff     = trial - {1'b0, k_r};
    ge       = (trial >= {1'b0, k_r});
    rem_nxt  = ge ? diff[bpc_pkg::K_W-1:0] : trial[bpc_pkg::K_W-1:0];
    q_nxt    = {q_r[bpc_pkg::DIV_W-2:0], ge};
    q_ext    = $signed({{(bpc_pkg::VAL_W-bpc_pkg::DIV_W){1'b0}}, q_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= raw[bpc_pkg::RAW_W-1];
        k_r    <= k_sel;
        rem_r  <= '0;
        q_r    <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(bpc_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        quot_r <= neg_r ? -q_ext : q_ext;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: sv/bpc_serial_mul.sv
// ----------------------------------------------------------------------------
// bpc_serial_mul: shift-add sign-magnitude multiplier
// Consumes one multiplier bit per cycle; optionally rounds the Q24 by Q24
// product back to Q24, half away from zero.
// ----------------------------------------------------------------------------
module bpc_serial_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bpc_pkg::mul_cmd_t                      cmd,
  input  logic signed [bpc_pkg::VAL_W-1:0]       a,
  input  logic signed [bpc_pkg::VAL_W-1:0]       b,
  output logic                                   done,
  output logic signed [bpc_pkg::VAL_W-1:0]       product
);

  localparam int P_W   = bpc_pkg::MA_W + bpc_pkg::MB_W + 1;
  localparam int H_W   = bpc_pkg::MA_W + 1;
  localparam int CNT_W = $clog2(bpc_pkg::MB_W);

  logic                             busy_r;
  logic                             fin_r;
  logic                             done_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             neg_r;
  logic                             rnd_r;
  logic [bpc_pkg::MA_W-1:0]         a_mag_r;
  logic [P_W-1:0]                   p_r;
  logic signed [bpc_pkg::VAL_W-1:0] product_r;

  logic signed [bpc_pkg::VAL_W-1:0] a_abs;
  logic signed [bpc_pkg::VAL_W-1:0] b_abs;
  logic [H_W-1:0]                   hi0;
  logic [H_W-1:0]                   hi_sum;
  logic [P_W-1:0]                   p_nxt;
  logic [bpc_pkg::VAL_W-2:0]        m;
  logic signed [bpc_pkg::VAL_W-1:0] m_ext;

  always_comb begin
    a_abs  = a[bpc_pkg::VAL_W-1] ? -a : a;
    b_abs  = b[bpc_pkg::VAL_W-1] ? -b : b;
    hi0    = cmd.rnd ? (H_W'(1) << (bpc_pkg::FRAC - 1)) : '0;
    hi_sum = p_r[P_W-1:bpc_pkg::MB_W] + (p_r[0] ? {1'b0, a_mag_r} : '0);
    p_nxt  = {1'b0, hi_sum, p_r[bpc_pkg::MB_W-1:1]};
    m      = rnd_r ? p_r[bpc_pkg::FRAC +: (bpc_pkg::VAL_W-1)] : p_r[bpc_pkg::VAL_W-2:0];
    m_ext  = $signed({1'b0, m});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (cmd.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        neg_r   <= a[bpc_pkg::VAL_W-1] ^ b[bpc_pkg::VAL_W-1];
        rnd_r   <= cmd.rnd;
        a_mag_r <= a_abs[bpc_pkg::MA_W-1:0];
        p_r     <= {hi0, b_abs[bpc_pkg::MB_W-1:0]};
      end else if (busy_r) begin
        p_r   <= p_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(bpc_pkg::MB_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        product_r <= neg_r ? -m_ext : m_ext;
      end
    end
  end

  assign done    = done_r;
  assign product = product_r;

endmodule

FILE: sv/baro_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top: barometric sensor compensation
// Steps: scaling, then products, then magnitude, rounding and saturation of the result.
// Throughput: one sample at a time; next transfer taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous): coefficients zero, oversampling 6, stored temperature zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bpc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bpc_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVP = 3'd1;
  localparam logic [2:0] ST_DIVT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_MAG  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;
  localparam logic [2:0] ST_SAT  = 3'd6;

  localparam logic [2:0] MS_TEMP = 3'd0;
  localparam logic [2:0] MS_A    = 3'd1;
  localparam logic [2:0] MS_B    = 3'd2;
  localparam logic [2:0] MS_P    = 3'd3;
  localparam logic [2:0] MS_D    = 3'd4;
  localparam logic [2:0] MS_T    = 3'd5;
  localparam logic [2:0] MS_E    = 3'd6;
  localparam logic [2:0] MS_F    = 3'd7;

  localparam int VW = bpc_pkg::VAL_W;
  localparam int OW = bpc_pkg::OUT_W;

  logic [2:0]                       state_r;
  logic                             launch_r;
  logic [2:0]                       step_r;
  logic                             kind_r;
  logic signed [bpc_pkg::RAW_W-1:0] raw_r;
  logic signed [bpc_pkg::RAW_W-1:0] last_temp_r;
  logic signed [VW-1:0]             psc_r;
  logic signed [VW-1:0]             tsc_r;
  logic signed [VW-1:0]             tmp_r;
  logic signed [VW-1:0]             t_r;
  logic signed [VW-1:0]             acc_r;
  logic                             neg_r;
  logic                             out_valid_r;
  bpc_pkg::out_item_t               out_data_r;

  logic [23:0]                      temp_coefs_r;
  logic [39:0]                      offset_coefs_r;
  logic [63:0]                      cross_coefs_r;
  logic [15:0]                      cubic_coef_r;
  logic [bpc_pkg::OS_W-1:0]         temp_os_r;
  logic [bpc_pkg::OS_W-1:0]         press_os_r;

  bpc_pkg::div_cmd_t                div_cmd;
  logic signed [bpc_pkg::RAW_W-1:0] div_raw;
  logic                             div_done;
  logic signed [VW-1:0]             div_quot;
  bpc_pkg::mul_cmd_t                mul_cmd;
  logic signed [VW-1:0]             mul_a;
  logic signed [VW-1:0]             mul_b;
  logic                             mul_done;
  logic signed [VW-1:0]             mul_res;

  logic signed [VW-1:0] c0_q, c1_v, c00_q, c10_q, c01_v, c11_q, c20_q, c21_v, c30_v;
  logic signed [VW-1:0] addend;
  logic signed [VW-1:0] sum_nxt;
  logic                 pos_ovf;
  logic                 neg_ovf;
  logic [OW-1:0]        sat_mag;
  logic [OW-1:0]        comp_nxt;
  logic                 out_load;

  always_comb begin
    c0_q  = VW'($signed(temp_coefs_r[23:12])) <<< (bpc_pkg::FRAC - 1);
    c1_v  = VW'($signed(temp_coefs_r[11:0]));
    c00_q = VW'($signed(offset_coefs_r[39:20])) <<< bpc_pkg::FRAC;
    c10_q = VW'($signed(offset_coefs_r[19:0])) <<< bpc_pkg::FRAC;
    c01_v = VW'($signed(cross_coefs_r[63:48]));
    c11_q = VW'($signed(cross_coefs_r[47:32])) <<< bpc_pkg::FRAC;
    c20_q = VW'($signed(cross_coefs_r[31:16])) <<< bpc_pkg::FRAC;
    c21_v = VW'($signed(cross_coefs_r[15:0]));
    c30_v = VW'($signed(cubic_coef_r));
  end

  always_comb begin
    div_cmd.start = launch_r && (state_r == ST_DIVP || state_r == ST_DIVT);
    div_cmd.code  = (state_r == ST_DIVP) ? press_os_r : temp_os_r;
    div_raw       = (state_r == ST_DIVP) ? raw_r : last_temp_r;
  end

  always_comb begin
    mul_cmd.start = launch_r && (state_r == ST_MUL);
    unique case (step_r)
      MS_TEMP: begin
        mul_a = tsc_r;  mul_b = c1_v;  mul_cmd.rnd = 1'b0; addend = c0_q;
      end
      MS_A: begin
        mul_a = psc_r;  mul_b = c30_v; mul_cmd.rnd = 1'b0; addend = c20_q;
      end
      MS_B: begin
        mul_a = tmp_r;  mul_b = psc_r; mul_cmd.rnd = 1'b1; addend = c10_q;
      end
      MS_P: begin
        mul_a = tmp_r;  mul_b = psc_r; mul_cmd.rnd = 1'b1; addend = c00_q;
      end
      MS_D: begin
        mul_a = psc_r;  mul_b = c21_v; mul_cmd.rnd = 1'b0; addend = c11_q;
      end
      MS_T: begin
        mul_a = tsc_r;  mul_b = psc_r; mul_cmd.rnd = 1'b1; addend = '0;
      end
      MS_E: begin
        mul_a = tmp_r;  mul_b = t_r;   mul_cmd.rnd = 1'b1; addend = acc_r;
      end
      MS_F: begin
        mul_a = tsc_r;  mul_b = c01_v; mul_cmd.rnd = 1'b0; addend = acc_r;
      end
    endcase
    sum_nxt = mul_res + addend;
  end

  always_comb begin
    pos_ovf  = |acc_r[VW-1:OW-1];
    neg_ovf  = (|acc_r[VW-1:OW]) || (acc_r[OW-1] && (|acc_r[OW-2:0]));
    priority if (!neg_r && pos_ovf) begin
      sat_mag = {1'b0, {(OW-1){1'b1}}};
    end else if (neg_r && neg_ovf) begin
      sat_mag = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat_mag = acc_r[OW-1:0];
    end
    comp_nxt = neg_r ? -sat_mag : sat_mag;
    out_load = (state_r == ST_SAT) && (!out_valid_r || !out_stall);
  end

  bpc_scale_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .raw   (div_raw),
    .done  (div_done),
    .quot  (div_quot)
  );

  bpc_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mul_cmd),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      launch_r       <= 1'b0;
      step_r         <= MS_TEMP;
      out_valid_r    <= 1'b0;
      last_temp_r    <= '0;
      temp_coefs_r   <= '0;
      offset_coefs_r <= '0;
      cross_coefs_r  <= '0;
      cubic_coef_r   <= '0;
      temp_os_r      <= 3'd6;
      press_os_r     <= 3'd6;
    end else begin
      launch_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bpc_pkg::CFG_TEMP_COEFS:   temp_coefs_r   <= cfg_data[23:0];
          bpc_pkg::CFG_OFFSET_COEFS: offset_coefs_r <= cfg_data[39:0];
          bpc_pkg::CFG_CROSS_COEFS:  cross_coefs_r  <= cfg_data;
          bpc_pkg::CFG_CUBIC_COEF:   cubic_coef_r   <= cfg_data[15:0];
          bpc_pkg::CFG_TEMP_OS:      temp_os_r      <= cfg_data[bpc_pkg::OS_W-1:0];
          bpc_pkg::CFG_PRESS_OS:     press_os_r     <= cfg_data[bpc_pkg::OS_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r.result_kind <= kind_r;
        out_data_r.compensated <= $signed(comp_nxt);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r   <= in_data.cmd;
            raw_r    <= in_data.raw_sample;
            if (!in_data.cmd) begin
              last_temp_r <= in_data.raw_sample;
            end
            state_r  <= in_data.cmd ? ST_DIVP : ST_DIVT;
            launch_r <= 1'b1;
          end
        end
        ST_DIVP: begin
          if (div_done) begin
            psc_r    <= div_quot;
            state_r  <= ST_DIVT;
            launch_r <= 1'b1;
          end
        end
        ST_DIVT: begin
          if (div_done) begin
            tsc_r    <= div_quot;
            step_r   <= kind_r ? MS_A : MS_TEMP;
            state_r  <= ST_MUL;
            launch_r <= 1'b1;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            unique case (step_r)
              MS_TEMP: begin
                acc_r   <= sum_nxt;
                state_r <= ST_MAG;
              end
              MS_A, MS_B, MS_D: begin
                tmp_r    <= sum_nxt;
                step_r   <= step_r + 3'd1;
                launch_r <= 1'b1;
              end
              MS_P, MS_E: begin
                acc_r    <= sum_nxt;
                step_r   <= step_r + 3'd1;
                launch_r <= 1'b1;
              end
              MS_T: begin
                t_r      <= mul_res;
                step_r   <= MS_E;
                launch_r <= 1'b1;
              end
              MS_F: begin
                acc_r   <= sum_nxt;
                state_r <= ST_MAG;
              end
            endcase
          end
        end
        ST_MAG: begin
          neg_r   <= acc_r[VW-1];
          acc_r   <= acc_r[VW-1] ? -acc_r : acc_r;
          state_r <= ST_RND;
        end
        ST_RND: begin
          acc_r   <= (acc_r + VW'(bpc_pkg::ROUND_Q8)) >>> bpc_pkg::Q8_SHIFT;
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

FILE: test/baro_pressure_temp_compensation_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top_tb: compensation block testbench
// Drives raw temperature and pressure samples through the block under
// changing calibration and oversampling settings. Each result is compared
// against an in-bench fixed-point predictor. Directed tests come first,
// then randomised traffic under three sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_top_tb;
  import bpc_pkg::*;

  localparam logic CMD_TEMP  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [OS_W-1:0] OS_SMALLEST_K = 3'd4;
  localparam logic [OS_W-1:0] OS_LARGEST_K  = 3'd3;

  localparam logic [RAW_W-1:0] RAW_MAX   = 24'h7FFFFF;
  localparam logic [RAW_W-1:0] RAW_MIN   = 24'h800000;
  localparam logic [RAW_W-1:0] RAW_MINUS = 24'hFFFFFF;

  localparam longint Q24_ONE  = 64'sd16777216;
  localparam longint Q24_HALF = 64'sd8388608;

  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [23:0] temp_coefs_r;
  logic [39:0] offset_coefs_r;
  logic [63:0] cross_coefs_r;
  logic [15:0] cubic_coef_r;
  logic [2:0]  temp_os_r;
  logic [2:0]  press_os_r;
  logic [23:0] last_temp_r;

  out_item_t pending_results[$];

  int in_idle_pct  = 36;
  int out_idle_pct = 65;
  int err_count    = 0;
  int temp_results = 0;
  int press_results = 0;
  int sat_results  = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;

  baro_pressure_temp_compensation_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint scale_q24(logic [23:0] raw, logic [2:0] code);
    longint k, m, r;
    case (code)
      3'd0: k = 524288;
      3'd1: k = 1572864;
      3'd2: k = 3670016;
      3'd3: k = 7864320;
      3'd4: k = 253952;
      3'd5: k = 516096;
      3'd6: k = 1040384;
      default: k = 2088960;
    endcase
    r = $signed(raw);
    m = (r < 0) ? -r : r;
    m = ((m <<< 24) + (k >>> 1)) / k;
    return (r < 0) ? -m : m;
  endfunction

  function automatic longint mul_q24(longint a, longint b);
    logic [63:0]  ma, mb, r;
    logic [127:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = {64'd0, ma} * {64'd0, mb} + (128'd1 << 23);
    r = p[87:24];
    if (r > 64'h7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
    return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] to_q8(longint x);
    logic [63:0] m;
    m = (x < 0) ? -x : x;
    m = (m + 64'h8000) >> 16;
    if (x >= 0 && m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    if (x < 0 && m > 64'h8000_0000) m = 64'h8000_0000;
    return (x < 0) ? -m[31:0] : m[31:0];
  endfunction

  function automatic out_item_t compensate(in_item_t it);
    out_item_t res;
    longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
    longint psc, tsc, a, b, p, d, e, acc;
    if (it.cmd == CMD_TEMP) begin
      c0 = $signed(temp_coefs_r[23:12]);
      c1 = $signed(temp_coefs_r[11:0]);
      last_temp_r = it.raw_sample;
      tsc = scale_q24(it.raw_sample, temp_os_r);
      acc = c0 * Q24_HALF + tsc * c1;
    end else begin
      c00 = $signed(offset_coefs_r[39:20]);
      c10 = $signed(offset_coefs_r[19:0]);
      c01 = $signed(cross_coefs_r[63:48]);
      c11 = $signed(cross_coefs_r[47:32]);
      c20 = $signed(cross_coefs_r[31:16]);
      c21 = $signed(cross_coefs_r[15:0]);
      c30 = $signed(cubic_coef_r);
      psc = scale_q24(it.raw_sample, press_os_r);
      tsc = scale_q24(last_temp_r, temp_os_r);
      a = c30 * psc + c20 * Q24_ONE;
      b = mul_q24(psc, a) + c10 * Q24_ONE;
      p = mul_q24(psc, b);
      d = c21 * psc + c11 * Q24_ONE;
      e = mul_q24(mul_q24(tsc, psc), d);
      acc = c00 * Q24_ONE + p + c01 * tsc + e;
    end
    res.result_kind = it.cmd;
    res.compensated = to_q8(acc);
    return res;
  endfunction

  function automatic logic [63:0] pick_coef(int w);
    logic [63:0] v;
    case ($urandom_range(7))
      0: v = (64'd1 << (w - 1)) - 64'd1;
      1: v = 64'd1 << (w - 1);
      2: v = 64'd0;
      default: v = {$urandom, $urandom};
    endcase
    return v & ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [23:0] pick_raw();
    case ($urandom_range(15))
      0: return RAW_MAX;
      1: return RAW_MIN;
      2: return '0;
      3: return RAW_MINUS;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic reset_model();
    temp_coefs_r   = '0;
    offset_coefs_r = '0;
    cross_coefs_r  = '0;
    cubic_coef_r   = '0;
    temp_os_r      = 3'd6;
    press_os_r     = 3'd6;
    last_temp_r    = '0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_count < MAX_REPORTS)
      $display("mismatch %s: got %0h, want %0h", what, got, want);
    err_count++;
  endtask

  task automatic send_sample(logic cmd, logic [RAW_W-1:0] raw);
    in_item_t it;
    it.cmd = cmd;
    it.raw_sample = raw;
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(compensate(it));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TEMP_COEFS:   temp_coefs_r   = data[23:0];
      CFG_OFFSET_COEFS: offset_coefs_r = data[39:0];
      CFG_CROSS_COEFS:  cross_coefs_r  = data;
      CFG_CUBIC_COEF:   cubic_coef_r   = data[15:0];
      CFG_TEMP_OS:      temp_os_r      = data[2:0];
      CFG_PRESS_OS:     press_os_r     = data[2:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic randomise_settings();
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[23:12] = pick_coef(12);
    d[11:0]  = pick_coef(12);
    cfg_write(CFG_TEMP_COEFS, d);
    d = {$urandom, $urandom};
    d[39:20] = pick_coef(20);
    d[19:0]  = pick_coef(20);
    cfg_write(CFG_OFFSET_COEFS, d);
    d[63:48] = pick_coef(16);
    d[47:32] = pick_coef(16);
    d[31:16] = pick_coef(16);
    d[15:0]  = pick_coef(16);
    cfg_write(CFG_CROSS_COEFS, d);
    d = {$urandom, $urandom};
    d[15:0] = pick_coef(16);
    cfg_write(CFG_CUBIC_COEF, d);
    cfg_write(CFG_TEMP_OS, {$urandom, $urandom});
    cfg_write(CFG_PRESS_OS, {$urandom, $urandom});
    if ($urandom_range(3) == 0)
      cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
  endtask

  // pressure with reset settings, then with coefficients but no temperature yet
  task automatic test_reset_state();
    send_sample(CMD_PRESS, RAW_MAX);
    wait_idle();
    randomise_settings();
    send_sample(CMD_PRESS, RAW_W'($urandom));
    send_sample(CMD_TEMP, '0);
    wait_idle();
  endtask

  // spare indexes must leave every register untouched
  task automatic test_register_map();
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '1);
    send_sample(CMD_TEMP, RAW_W'($urandom));
    send_sample(CMD_PRESS, RAW_W'($urandom));
    wait_idle();
  endtask

  task automatic test_extreme_values();
    for (int s = 0; s < 2; s++) begin
      cfg_write(CFG_TEMP_COEFS,   s ? 64'h800800 : 64'h7FF7FF);
      cfg_write(CFG_OFFSET_COEFS, s ? 64'h80000_80000 : 64'h7FFFF_7FFFF);
      cfg_write(CFG_CROSS_COEFS,  s ? 64'h8000_8000_8000_8000 : 64'h7FFF_7FFF_7FFF_7FFF);
      cfg_write(CFG_CUBIC_COEF,   s ? 64'hFFFF_FFFF_FFFF_8000 : 64'h7FFF);
      cfg_write(CFG_TEMP_OS,      CFG_DATA_W'(s ? OS_LARGEST_K : OS_SMALLEST_K));
      cfg_write(CFG_PRESS_OS,     CFG_DATA_W'(s ? OS_LARGEST_K : OS_SMALLEST_K));
      send_sample(CMD_TEMP, RAW_MAX);
      send_sample(CMD_PRESS, RAW_MAX);
      send_sample(CMD_PRESS, RAW_MIN);
      send_sample(CMD_TEMP, RAW_MIN);
      send_sample(CMD_PRESS, RAW_MINUS);
      send_sample(CMD_PRESS, 24'h000001);
      wait_idle();
    end
  endtask

  // stored reading is rescaled with the temperature code current at the pressure step
  task automatic test_oversampling_change();
    randomise_settings();
    cfg_write(CFG_TEMP_OS, CFG_DATA_W'(3'd0));
    send_sample(CMD_TEMP, RAW_W'($urandom));
    wait_idle();
    cfg_write(CFG_TEMP_OS, CFG_DATA_W'(OS_SMALLEST_K));
    send_sample(CMD_PRESS, RAW_W'($urandom));
    wait_idle();
    cfg_write(CFG_PRESS_OS, CFG_DATA_W'(3'd7));
    send_sample(CMD_PRESS, RAW_W'($urandom));
    wait_idle();
  endtask

  task automatic test_random_traffic(int n_items, int sender_pct, int receiver_pct);
    int sent;
    int burst;
    sent = 0;
    in_idle_pct  = sender_pct;
    out_idle_pct = receiver_pct;
    while (sent < n_items) begin
      wait_idle();
      randomise_settings();
      burst = $urandom_range(10, 60);
      send_sample(CMD_TEMP, pick_raw());
      sent++;
      for (int i = 1; i < burst && sent < n_items; i++) begin
        send_sample(($urandom_range(99) < 30) ? CMD_TEMP : CMD_PRESS, pick_raw());
        sent++;
      end
    end
    wait_idle();
  endtask

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < out_idle_pct);

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_data), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_kind !== want.result_kind)
          report_mismatch("result_kind", 64'(out_data.result_kind), 64'(want.result_kind));
        if (out_data.compensated !== want.compensated)
          report_mismatch("compensated", 64'(out_data.compensated), 64'(want.compensated));
        if (want.result_kind == CMD_TEMP) temp_results++;
        else press_results++;
        if (want.compensated == 32'h7FFF_FFFF || want.compensated == 32'h8000_0000)
          sat_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_register_map();
    test_extreme_values();
    test_oversampling_change();
    test_random_traffic(430, 36, 65);
    test_random_traffic(430, 65, 36);
    test_random_traffic(430, 0, 0);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 64'(pending_results.size()), '0);
    $display("run covered %0d temperature and %0d pressure results, %0d saturated",
             temp_results, press_results, sat_results);
    $display("%0d register writes across random and extreme settings, %0d mismatches",
             cfg_writes, err_count);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
